// ----- design/lzfu_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the LZ unit decompressor.
package lzfu_pkg;

   // History window depth in units; must be a power of two (256 to 32768).
   localparam int WINDOW_UNITS = 4096;
   localparam int PTR_W        = $clog2(WINDOW_UNITS);

   localparam int UNIT_W       = 32;
   localparam int WORD16_W     = 16;
   localparam int FLAG_BITS    = 16;
   localparam int FLAG_CNT_W   = 5;
   localparam int COPY_W       = 6;
   localparam int SB_W         = 3;
   localparam int ACT_W        = 2;
   localparam int ERR_W        = 2;
   localparam int CSR_IDX_W    = 2;

   localparam logic [COPY_W-1:0] MAX_COPY     = 6'd63;
   localparam logic [SB_W-1:0]   MAX_SIZE_BITS = 3'd5;

   // Word kinds.
   localparam logic [ACT_W-1:0] ACT_FLAG = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RAW  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COPY = 2'd2;

   // Result error codes.
   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_WRONG_KIND = 2'd1;
   localparam logic [ERR_W-1:0] ERR_BAD_OFFSET = 2'd2;
   localparam logic [ERR_W-1:0] ERR_OVERRUN    = 2'd3;

   // Unit width modes.
   localparam logic [1:0] MODE_8  = 2'd0;
   localparam logic [1:0] MODE_16 = 2'd1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_MODE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_UNITS = 2'd3;

   localparam logic [SB_W-1:0]   RESET_SIZE_BITS  = 3'd4;
   localparam logic [COPY_W-1:0] RESET_MIN_LENGTH = 6'd3;

   typedef struct packed {
      logic             flag_load;
      logic             raw_take;
      logic             err_push;
      logic [ERR_W-1:0] err_code;
      logic             copy_start;
      logic             copy_read;
      logic             copy_write;
   } cmd_type;

   typedef struct packed {
      logic             finished;
      logic             kind_ok;
      logic [ACT_W-1:0] action;
      logic             bad_offset;
      logic             len_zero;
      logic             count_last;
      logic             out_free;
   } status_type;

endpackage

// ----- design/lzfu_ctrl.sv -----
// Controller state machine: sequences item decode and copy replay through the datapath.
module lzfu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lzfu_pkg::status_type status,
   output lzfu_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COPY_RD = 3'b010,
      ST_COPY_WR = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !status.finished) begin
               if (!status.kind_ok) begin
                  cmd.err_push = 1'b1;
                  cmd.err_code = lzfu_pkg::ERR_WRONG_KIND;
               end else begin
                  unique case (status.action)
                     lzfu_pkg::ACT_FLAG: cmd.flag_load = 1'b1;
                     lzfu_pkg::ACT_RAW:  cmd.raw_take  = 1'b1;
                     lzfu_pkg::ACT_COPY: begin
                        if (status.bad_offset) begin
                           cmd.err_push = 1'b1;
                           cmd.err_code = lzfu_pkg::ERR_BAD_OFFSET;
                        end else begin
                           cmd.copy_start = 1'b1;
                           if (!status.len_zero) begin
                              state_in = ST_COPY_RD;
                           end
                        end
                     end
                     default: cmd.err_push = 1'b0;
                  endcase
               end
            end
         end
         ST_COPY_RD: begin
            cmd.copy_read = 1'b1;
            state_in      = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            if (status.out_free) begin
               cmd.copy_write = 1'b1;
               state_in       = status.count_last ? ST_IDLE : ST_COPY_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Every window write of a copy is preceded by a read issued for it.
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_write |-> ($past(state_ff) == ST_COPY_RD || $past(state_ff) == ST_COPY_WR))
      else $error("copy write without a preceding window read");

   // A copy always ends back in idle after its last unit.
   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.copy_write && status.count_last) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after last copy unit");

endmodule

// ----- design/lzfu_datapath.sv -----
// Datapath: configuration, flag and pointer state, history window RAM and result register.
module lzfu_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lzfu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lzfu_pkg::UNIT_W-1:0]      csr_write_data,
   input  logic [lzfu_pkg::ACT_W-1:0]       req_action,
   input  logic [lzfu_pkg::UNIT_W-1:0]      req_word_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lzfu_pkg::UNIT_W-1:0]      rsp_unit_value,
   output logic                             rsp_last_of_run,
   output logic                             rsp_finished,
   output logic [lzfu_pkg::ERR_W-1:0]       rsp_error_code,
   input  lzfu_pkg::cmd_type                cmd,
   output lzfu_pkg::status_type             status
);

   // Configuration registers.
   logic [lzfu_pkg::SB_W-1:0]   size_bits_ff;
   logic [lzfu_pkg::COPY_W-1:0] min_length_ff;
   logic [1:0]                  unit_mode_ff;
   logic [lzfu_pkg::UNIT_W-1:0] total_units_ff;

   // Decoder state.
   logic [lzfu_pkg::PTR_W-1:0]      write_ptr_ff, write_ptr_in;
   logic [lzfu_pkg::UNIT_W-1:0]     units_written_ff, units_written_in;
   logic [lzfu_pkg::FLAG_BITS-1:0]  flag_shift_ff, flag_shift_in;
   logic [lzfu_pkg::FLAG_CNT_W-1:0] flags_left_ff, flags_left_in;
   logic [lzfu_pkg::COPY_W-1:0]     copy_count_ff, copy_count_in;
   logic [lzfu_pkg::PTR_W-1:0]      copy_offset_ff, copy_offset_in;
   logic                            copy_over_ff, copy_over_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lzfu_pkg::UNIT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_fin_ff, rsp_fin_in;
   logic [lzfu_pkg::ERR_W-1:0]   rsp_err_ff, rsp_err_in;

   // History window.
   logic [lzfu_pkg::UNIT_W-1:0] window_mem [lzfu_pkg::WINDOW_UNITS];
   logic [lzfu_pkg::UNIT_W-1:0] rd_data_ff;
   logic [lzfu_pkg::PTR_W-1:0]  rd_addr;
   logic                        win_we;
   logic [lzfu_pkg::UNIT_W-1:0] win_wdata;

   // Decode of the presented item.
   logic [lzfu_pkg::ACT_W-1:0]    expected;
   logic [lzfu_pkg::SB_W-1:0]     sb;
   logic [lzfu_pkg::WORD16_W-1:0] copy_word;
   logic [4:0]                    len_mask;
   logic [lzfu_pkg::COPY_W:0]     len_sum;
   logic [lzfu_pkg::COPY_W-1:0]   len_sat;
   logic [lzfu_pkg::COPY_W-1:0]   len_clamped;
   logic [lzfu_pkg::WORD16_W-1:0] offset;
   logic [lzfu_pkg::UNIT_W-1:0]   units_left;
   logic                          overrun;
   logic [lzfu_pkg::UNIT_W-1:0]   unit_mask;
   logic [lzfu_pkg::UNIT_W-1:0]   raw_value;
   logic [lzfu_pkg::UNIT_W-1:0]   written_plus1;
   logic                          push;

   always_comb begin
      if (flags_left_ff == '0) begin
         expected = lzfu_pkg::ACT_FLAG;
      end else begin
         expected = flag_shift_ff[0] ? lzfu_pkg::ACT_RAW : lzfu_pkg::ACT_COPY;
      end
      sb = (size_bits_ff > lzfu_pkg::MAX_SIZE_BITS) ? lzfu_pkg::MAX_SIZE_BITS : size_bits_ff;
      copy_word   = req_word_value[lzfu_pkg::WORD16_W-1:0];
      len_mask    = 5'((6'd1 << sb) - 6'd1);
      len_sum     = {2'b00, copy_word[4:0] & len_mask} + {1'b0, min_length_ff};
      len_sat     = (len_sum > {1'b0, lzfu_pkg::MAX_COPY})
                    ? lzfu_pkg::MAX_COPY : len_sum[lzfu_pkg::COPY_W-1:0];
      offset      = copy_word >> sb;
      units_left  = total_units_ff - units_written_ff;
      overrun     = {{(lzfu_pkg::UNIT_W-lzfu_pkg::COPY_W){1'b0}}, len_sat} > units_left;
      len_clamped = overrun ? units_left[lzfu_pkg::COPY_W-1:0] : len_sat;
      unique case (unit_mode_ff)
         lzfu_pkg::MODE_8:  unit_mask = 32'h0000_00FF;
         lzfu_pkg::MODE_16: unit_mask = 32'h0000_FFFF;
         default:           unit_mask = 32'hFFFF_FFFF;
      endcase
      raw_value     = req_word_value & unit_mask;
      written_plus1 = units_written_ff + 32'd1;
   end

   always_comb begin
      status.finished   = units_written_ff >= total_units_ff;
      status.kind_ok    = req_action == expected;
      status.action     = req_action;
      status.bad_offset = (offset == '0)
         || ({{(lzfu_pkg::UNIT_W-lzfu_pkg::WORD16_W){1'b0}}, offset} > units_written_ff)
         || ({{(lzfu_pkg::UNIT_W-lzfu_pkg::WORD16_W){1'b0}}, offset}
             > lzfu_pkg::UNIT_W'(lzfu_pkg::WINDOW_UNITS));
      status.len_zero   = len_clamped == '0;
      status.count_last = copy_count_ff == lzfu_pkg::COPY_W'(1);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Decoder state updates.
   always_comb begin
      write_ptr_in     = write_ptr_ff;
      units_written_in = units_written_ff;
      flag_shift_in    = flag_shift_ff;
      flags_left_in    = flags_left_ff;
      copy_count_in    = copy_count_ff;
      copy_offset_in   = copy_offset_ff;
      copy_over_in     = copy_over_ff;
      if (cmd.raw_take || cmd.copy_write) begin
         write_ptr_in     = write_ptr_ff + lzfu_pkg::PTR_W'(1);
         units_written_in = written_plus1;
      end
      if (cmd.flag_load) begin
         flag_shift_in = req_word_value[lzfu_pkg::FLAG_BITS-1:0];
         flags_left_in = lzfu_pkg::FLAG_CNT_W'(lzfu_pkg::FLAG_BITS);
      end else if (cmd.raw_take || cmd.copy_start) begin
         flag_shift_in = flag_shift_ff >> 1;
         flags_left_in = flags_left_ff - lzfu_pkg::FLAG_CNT_W'(1);
      end
      if (cmd.copy_start) begin
         copy_count_in  = len_clamped;
         copy_offset_in = offset[lzfu_pkg::PTR_W-1:0];
         copy_over_in   = overrun;
      end else if (cmd.copy_write) begin
         copy_count_in = copy_count_ff - lzfu_pkg::COPY_W'(1);
      end
   end

   // Result register: loaded on a push, cleared once the transfer completes.
   always_comb begin
      push         = cmd.err_push || cmd.raw_take || cmd.copy_write;
      rsp_valid_in = push ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_err_in   = rsp_err_ff;
      priority if (cmd.err_push) begin
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         rsp_fin_in   = 1'b0;
         rsp_err_in   = cmd.err_code;
      end else if (cmd.raw_take) begin
         rsp_value_in = raw_value;
         rsp_last_in  = 1'b1;
         rsp_fin_in   = written_plus1 >= total_units_ff;
         rsp_err_in   = lzfu_pkg::ERR_NONE;
      end else if (cmd.copy_write) begin
         rsp_value_in = rd_data_ff;
         rsp_last_in  = status.count_last;
         rsp_fin_in   = written_plus1 >= total_units_ff;
         rsp_err_in   = copy_over_ff ? lzfu_pkg::ERR_OVERRUN : lzfu_pkg::ERR_NONE;
      end
   end

   assign rd_addr   = write_ptr_ff - copy_offset_ff;
   assign win_we    = cmd.raw_take || cmd.copy_write;
   assign win_wdata = cmd.raw_take ? raw_value : rd_data_ff;

   always_ff @(posedge clock) begin
      if (win_we) begin
         window_mem[write_ptr_ff] <= win_wdata;
      end
      if (cmd.copy_read) begin
         rd_data_ff <= window_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_bits_ff     <= lzfu_pkg::RESET_SIZE_BITS;
         min_length_ff    <= lzfu_pkg::RESET_MIN_LENGTH;
         unit_mode_ff     <= lzfu_pkg::MODE_8;
         total_units_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lzfu_pkg::CSR_SIZE_BITS:
               size_bits_ff   <= csr_write_data[lzfu_pkg::SB_W-1:0];
            lzfu_pkg::CSR_MIN_LENGTH:
               min_length_ff  <= csr_write_data[lzfu_pkg::COPY_W-1:0];
            lzfu_pkg::CSR_UNIT_MODE:
               unit_mode_ff   <= csr_write_data[1:0];
            lzfu_pkg::CSR_TOTAL_UNITS:
               total_units_ff <= csr_write_data;
            default:
               total_units_ff <= total_units_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff     <= '0;
         units_written_ff <= '0;
         flag_shift_ff    <= '0;
         flags_left_ff    <= '0;
         copy_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         write_ptr_ff     <= write_ptr_in;
         units_written_ff <= units_written_in;
         flag_shift_ff    <= flag_shift_in;
         flags_left_ff    <= flags_left_in;
         copy_count_ff    <= copy_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_offset_ff <= copy_offset_in;
      copy_over_ff   <= copy_over_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_err_ff     <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_value  = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_error_code  = rsp_err_ff;

   // A new result never overwrites one that is still waiting for its transfer.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten before transfer");

   // Copy units are only written while the copy still has units to go.
   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_write |-> copy_count_ff != '0)
      else $error("copy write with empty copy count");

   // The last unit of a copy is flagged as the end of the run.
   a_copy_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.copy_write && copy_count_ff == lzfu_pkg::COPY_W'(1))
      |=> (rsp_valid_ff && rsp_last_ff))
      else $error("last copy unit not marked last_of_run");

endmodule

// ----- design/lz_flagged_unit_decompressor_core.sv -----
// Top level of the LZ unit decompressor: controller plus datapath.
//
//  channel  direction  handshake                  payload
//  req      in         req_valid / req_stall      req_action, req_word_value
//  rsp      out        rsp_valid / rsp_stall      rsp_unit_value, rsp_last_of_run,
//                                                 rsp_finished, rsp_error_code
//  csr      in         csr_write_enable           csr_index, csr_write_data
//
// Flag words, raw units and rejected words are handled directly in the idle state.
// A copy is decoded in idle, then each unit has a read and a write state: the window RAM
// read is registered and the unit is written back before the next read is issued.
// Reset is synchronous; it clears decoder state, not copy offset, overrun flag or window.
// While a result waits on rsp_stall, the block stalls new input and holds its copy.
module lz_flagged_unit_decompressor_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [lzfu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lzfu_pkg::UNIT_W-1:0]    csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lzfu_pkg::ACT_W-1:0]     req_action,
   input  logic [lzfu_pkg::UNIT_W-1:0]    req_word_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lzfu_pkg::UNIT_W-1:0]    rsp_unit_value,
   output logic                           rsp_last_of_run,
   output logic                           rsp_finished,
   output logic [lzfu_pkg::ERR_W-1:0]     rsp_error_code
);

   lzfu_pkg::cmd_type    cmd;
   lzfu_pkg::status_type status;

   lzfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lzfu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_action       (req_action),
      .req_word_value   (req_word_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_unit_value   (rsp_unit_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_finished     (rsp_finished),
      .rsp_error_code   (rsp_error_code),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
